>>> hw/rtl/fpr_pkg.sv
// Shared types, constants and helpers for the false-position root finder.
`timescale 1ns / 1ps
package fpr_pkg;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 224;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // configuration register indexes
  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_STEPS = 2'd2;
  localparam logic [1:0] REG_ERRLIM = 2'd3;

  // result status codes
  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_ZERO = 3'd1;
  localparam logic [2:0] ST_CONV = 3'd2;
  localparam logic [2:0] ST_STEPS = 3'd3;
  localparam logic [2:0] ST_DIVZ = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_POLY_LO,
    OP_POLY_HI,
    OP_POLY_R,
    OP_MUL_Q,
    OP_DIV_Q,
    OP_SET_XR,
    OP_MUL_ERR,
    OP_DIV_ERR,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic poly_done;
    logic div_done;
    logic den_zero;
    logic xr_zero;
    logic out_full;
    logic run_end;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> hw/rtl/fpr_div.sv
// Unsigned restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module fpr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import fpr_pkg::*;

  localparam logic [6:0] DIV_STEPS = 7'd64;

  logic        busy;
  logic [6:0]  cnt;
  logic [32:0] rem;
  logic [32:0] dvs;
  logic [33:0] sh;
  logic        fits;

  assign sh   = {rem, quo[63]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_STEPS;
      rem  <= '0;
      quo  <= num;
      dvs  <= den;
    end else if (busy) begin
      rem <= fits ? 33'(sh - {1'b0, dvs}) : sh[32:0];
      quo <= {quo[62:0], fits};
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/fpr_poly_eval.sv
// Term store and polynomial evaluator on one shared 32x32 multiplier.
`timescale 1ns / 1ps
module fpr_poly_eval #(
  parameter int MAX_TERMS = 16,
  parameter int MAX_POWER = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               store_we,
  input  logic signed [31:0] store_coeff,
  input  logic [3:0]         store_power,
  input  logic               clear,
  input  logic               start,
  input  logic signed [31:0] x,
  output logic               done,
  output logic signed [31:0] result
);
  import fpr_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int PW_W  = $clog2(MAX_POWER + 1);
  localparam int ACC_W = 49 + CNT_W;

  typedef enum logic [2:0] {P_IDLE, P_TERM, P_PMUL, P_PUPD, P_CMUL, P_ACC} pstate_t;

  pstate_t                  state;
  logic signed [31:0]       coeff_mem [MAX_TERMS];
  logic [PW_W-1:0]          power_mem [MAX_TERMS];
  logic [CNT_W-1:0]         term_count;
  logic [CNT_W-1:0]         idx;
  logic [PW_W-1:0]          k;
  logic signed [31:0]       pw;
  logic signed [31:0]       x_reg;
  logic signed [63:0]       prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       mul_a;
  logic signed [63:0]       rnd;
  logic [PW_W-1:0]          power_clamped;
  logic [IDX_W-1:0]         sel;

  assign sel   = idx[IDX_W-1:0];
  assign mul_a = (state == P_CMUL) ? coeff_mem[sel] : x_reg;
  // round to nearest, halves upward
  assign rnd   = (prod + 64'sd32768) >>> 16;
  assign power_clamped = (32'(store_power) > MAX_POWER) ? PW_W'(MAX_POWER)
                                                        : PW_W'(store_power);

  always_ff @(posedge clk) begin
    if (store_we && (term_count < CNT_W'(MAX_TERMS))) begin
      coeff_mem[term_count[IDX_W-1:0]] <= store_coeff;
      power_mem[term_count[IDX_W-1:0]] <= power_clamped;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state      <= P_IDLE;
      term_count <= '0;
    end else begin
      if (clear) begin
        term_count <= '0;
      end else if (store_we && (term_count < CNT_W'(MAX_TERMS))) begin
        term_count <= term_count + CNT_W'(1);
      end
      unique case (state)
        P_IDLE: begin
          if (start) begin
            x_reg <= x;
            idx   <= '0;
            acc   <= '0;
            state <= P_TERM;
          end
        end
        P_TERM: begin
          if (idx == term_count) begin
            result <= sat32(64'(acc));
            done   <= 1'b1;
            state  <= P_IDLE;
          end else begin
            pw    <= Q_ONE;
            k     <= '0;
            state <= P_PMUL;
          end
        end
        P_PMUL: begin
          if (k == power_mem[sel]) begin
            state <= P_CMUL;
          end else begin
            prod  <= 64'(mul_a) * 64'(pw);
            state <= P_PUPD;
          end
        end
        P_PUPD: begin
          pw    <= sat32(rnd);
          k     <= k + PW_W'(1);
          state <= P_PMUL;
        end
        P_CMUL: begin
          prod  <= 64'(mul_a) * 64'(pw);
          state <= P_ACC;
        end
        P_ACC: begin
          acc   <= acc + ACC_W'(rnd);
          idx   <= idx + CNT_W'(1);
          state <= P_TERM;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/fpr_datapath.sv
// Datapath: config registers, bracket state, estimate and error math, result register.
`timescale 1ns / 1ps
module fpr_datapath #(
  parameter int MAX_TERMS = 16,
  parameter int MAX_POWER = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fpr_pkg::dp_cmd_t              cmd,
  output fpr_pkg::dp_status_t           stat,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic signed [31:0]            coefficient,
  input  logic [3:0]                    power,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fpr_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast
);
  import fpr_pkg::*;

  typedef enum logic [1:0] {TGT_LO, TGT_HI, TGT_R} tgt_t;

  localparam logic [63:0] PCT_SCALE = 64'd6553600;
  localparam logic [63:0] Q_CLAMP   = 64'h0000_0100_0000_0000;
  localparam logic [30:0] ERR_MAX   = 31'h7fff_ffff;

  logic signed [31:0] lower_bound, upper_bound;
  logic [6:0]         max_steps;
  logic [30:0]        error_limit;

  logic signed [31:0] lo, hi, fl, fu, fr, xr, prev;
  logic signed [64:0] prod_q;
  logic [63:0]        err_num;
  logic [6:0]         step;
  logic               run_end;
  tgt_t               tgt;

  logic               poly_start, poly_done;
  logic signed [31:0] poly_x, poly_res;
  logic               div_start, div_done;
  logic [63:0]        div_num, quo;
  logic [32:0]        div_den;

  logic signed [32:0] den, lo_minus_hi, d;
  logic [64:0]        prod_mag;
  logic [32:0]        den_mag, d_abs;
  logic [31:0]        xr_abs;
  logic               q_neg;
  logic [63:0]        qmag;
  logic signed [41:0] q_s;
  logic signed [42:0] diff;
  logic [6:0]         steps_eff;
  logic [30:0]        err_val;
  logic [2:0]         st_val;
  logic               den_zero, xr_zero;
  logic               flip_hi, flip_lo;

  assign den         = 33'(fl) - 33'(fu);
  assign lo_minus_hi = 33'(lo) - 33'(hi);
  assign den_zero    = (fl == fu);
  assign xr_zero     = (xr == 32'sd0);
  assign prod_mag    = prod_q[64] ? 65'(-prod_q) : 65'(prod_q);
  assign den_mag     = den[32] ? 33'(-den) : 33'(den);
  assign q_neg       = prod_q[64] ^ den[32];
  assign qmag        = (quo > Q_CLAMP) ? Q_CLAMP : quo;
  assign q_s         = q_neg ? -$signed({1'b0, qmag[40:0]}) : $signed({1'b0, qmag[40:0]});
  assign diff        = 43'(hi) - 43'(q_s);
  assign d           = 33'(xr) - 33'(prev);
  assign d_abs       = d[32] ? 33'(-d) : 33'(d);
  assign xr_abs      = xr[31] ? 32'(-xr) : 32'(xr);

  assign steps_eff = (max_steps == 7'd0) ? 7'd1 : (max_steps > 7'd64) ? 7'd64 : max_steps;

  // strictly opposite signs
  assign flip_hi = ((fl < 0) && (fr > 0)) || ((fl > 0) && (fr < 0));
  assign flip_lo = ((fu < 0) && (fr > 0)) || ((fu > 0) && (fr < 0));

  always_comb begin
    if (den_zero) begin
      err_val = '0;
    end else if (xr_zero) begin
      err_val = ERR_MAX;
    end else if (quo > 64'(ERR_MAX)) begin
      err_val = ERR_MAX;
    end else begin
      err_val = quo[30:0];
    end
  end

  always_comb begin
    priority if (den_zero) begin
      st_val = ST_DIVZ;
    end else if (xr_zero) begin
      st_val = ST_ZERO;
    end else if (err_val < error_limit) begin
      st_val = ST_CONV;
    end else if (step + 7'd1 == steps_eff) begin
      st_val = ST_STEPS;
    end else begin
      st_val = ST_RUN;
    end
  end

  assign poly_start = (cmd.op == OP_POLY_LO) || (cmd.op == OP_POLY_HI) || (cmd.op == OP_POLY_R);
  assign div_start  = (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_ERR);

  always_comb begin
    unique case (cmd.op)
      OP_POLY_LO: poly_x = lo;
      OP_POLY_HI: poly_x = hi;
      default:    poly_x = xr;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_DIV_Q) begin
      div_num = prod_mag[63:0];
      div_den = den_mag;
    end else begin
      div_num = err_num;
      div_den = {1'b0, xr_abs};
    end
  end

  fpr_poly_eval #(
    .MAX_TERMS(MAX_TERMS),
    .MAX_POWER(MAX_POWER)
  ) u_poly (
    .clk        (clk),
    .rst        (rst),
    .store_we   (cmd.store),
    .store_coeff(coefficient),
    .store_power(power),
    .clear      (cmd.op == OP_CLEAR),
    .start      (poly_start),
    .x          (poly_x),
    .done       (poly_done),
    .result     (poly_res)
  );

  fpr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  assign stat.poly_done = poly_done;
  assign stat.div_done  = div_done;
  assign stat.den_zero  = den_zero;
  assign stat.xr_zero   = xr_zero;
  assign stat.out_full  = m_tvalid && !m_tready;
  assign stat.run_end   = run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= 32'sd0;
      upper_bound <= Q_ONE;
      max_steps   <= 7'd10;
      error_limit <= 31'(Q_ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER:  lower_bound <= cfg_data;
        REG_UPPER:  upper_bound <= cfg_data;
        REG_STEPS:  max_steps   <= cfg_data[6:0];
        REG_ERRLIM: error_limit <= cfg_data[30:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      run_end  <= 1'b0;
      step     <= '0;
      lo       <= '0;
      hi       <= '0;
      prev     <= '0;
    end else begin
      // a new result may load in the cycle the previous one transfers
      if (cmd.op == OP_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (poly_done) begin
        unique case (tgt)
          TGT_LO:  fl <= poly_res;
          TGT_HI:  fu <= poly_res;
          default: fr <= poly_res;
        endcase
      end
      unique case (cmd.op)
        OP_START: begin
          lo      <= lower_bound;
          hi      <= upper_bound;
          prev    <= '0;
          step    <= '0;
          run_end <= 1'b0;
        end
        OP_POLY_LO: tgt <= TGT_LO;
        OP_POLY_HI: tgt <= TGT_HI;
        OP_POLY_R:  tgt <= TGT_R;
        OP_MUL_Q:   prod_q <= 65'(fu) * 65'(lo_minus_hi);
        OP_SET_XR:  xr <= sat32(64'(diff));
        OP_MUL_ERR: err_num <= 64'(d_abs) * PCT_SCALE;
        OP_EMIT: begin
          m_tdata  <= {1'b0, err_val,
                       den_zero ? 32'sd0 : fr,
                       den_zero ? 32'sd0 : xr,
                       fu, fl, hi, lo};
          m_tuser  <= st_val;
          m_tlast  <= (st_val != ST_RUN);
          run_end  <= (st_val != ST_RUN);
          step     <= step + 7'd1;
          if (!den_zero) begin
            prev <= xr;
            if (!xr_zero) begin
              if (flip_hi) begin
                hi <= xr;
              end else if (flip_lo) begin
                lo <= xr;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/fpr_ctrl.sv
// Controller: sequences term loading and the iteration steps of each run.
`timescale 1ns / 1ps
module fpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tlast,
  output logic                s_tready,
  input  fpr_pkg::dp_status_t stat,
  output fpr_pkg::dp_cmd_t    cmd
);
  import fpr_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE, C_START, C_FLO, C_FLO_W, C_FHI, C_FHI_W, C_CHECK, C_MULQ, C_DIVQ,
    C_DIVQ_W, C_XR, C_FR, C_FR_W, C_MULE, C_DIVE, C_DIVE_W, C_EMIT, C_NEXT
  } cstate_t;

  cstate_t state;

  assign s_tready  = (state == C_IDLE);

  always_comb begin
    cmd.store = (state == C_IDLE) && s_tvalid;
    unique case (state)
      C_START: cmd.op = OP_START;
      C_FLO:   cmd.op = OP_POLY_LO;
      C_FHI:   cmd.op = OP_POLY_HI;
      C_MULQ:  cmd.op = OP_MUL_Q;
      C_DIVQ:  cmd.op = OP_DIV_Q;
      C_XR:    cmd.op = OP_SET_XR;
      C_FR:    cmd.op = OP_POLY_R;
      C_MULE:  cmd.op = OP_MUL_ERR;
      C_DIVE:  cmd.op = OP_DIV_ERR;
      C_EMIT:  cmd.op = stat.out_full ? OP_NONE : OP_EMIT;
      C_NEXT:  cmd.op = stat.run_end ? OP_CLEAR : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE:   if (s_tvalid && s_tlast) state <= C_START;
        C_START:  state <= C_FLO;
        C_FLO:    state <= C_FLO_W;
        C_FLO_W:  if (stat.poly_done) state <= C_FHI;
        C_FHI:    state <= C_FHI_W;
        C_FHI_W:  if (stat.poly_done) state <= C_CHECK;
        C_CHECK:  state <= stat.den_zero ? C_EMIT : C_MULQ;
        C_MULQ:   state <= C_DIVQ;
        C_DIVQ:   state <= C_DIVQ_W;
        C_DIVQ_W: if (stat.div_done) state <= C_XR;
        C_XR:     state <= C_FR;
        C_FR:     state <= C_FR_W;
        C_FR_W:   if (stat.poly_done) state <= stat.xr_zero ? C_EMIT : C_MULE;
        C_MULE:   state <= C_DIVE;
        C_DIVE:   state <= C_DIVE_W;
        C_DIVE_W: if (stat.div_done) state <= C_EMIT;
        C_EMIT:   if (!stat.out_full) state <= C_NEXT;
        C_NEXT:   state <= stat.run_end ? C_IDLE : C_FLO;
        default:  state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/false_position_poly_root.sv
// Top level of the false-position polynomial root finder.
// A term transfer is accepted while idle; the term marked last starts a run.
// Each iteration evaluates the polynomial at up to three points and runs up to two divisions.
// One run at a time; no term is taken until the run's final result is registered.
// Synchronous reset clears control state and loads the register defaults.
`timescale 1ns / 1ps
module false_position_poly_root #(
  parameter int MAX_TERMS = 16,
  parameter int MAX_POWER = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fpr_pkg::S_DATA_W-1:0]  s_tdata,  // coefficient[31:0], power[35:32]
  input  logic                          s_tlast,  // last_term
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // bracket_low, bracket_high, value_at_low, value_at_high, root_estimate,
  // value_at_root (32 each), approx_error[222:192]
  output logic [fpr_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [2:0]                    m_tuser,  // status
  output logic                          m_tlast,  // last
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import fpr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  fpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tlast (s_tlast),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  fpr_datapath #(
    .MAX_TERMS(MAX_TERMS),
    .MAX_POWER(MAX_POWER)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coefficient(s_tdata[31:0]),
    .power      (s_tdata[35:32]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

>>> hw/rtl/fpr_checker.sv
// Port-level checks for the root finder, bound to the top level.
`timescale 1ns / 1ps
module fpr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [fpr_pkg::S_DATA_W-1:0]  s_tdata,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fpr_pkg::M_DATA_W-1:0]  m_tdata,
  input logic [2:0]                    m_tuser,
  input logic                          m_tlast,
  input logic                          cfg_we,
  input logic [1:0]                    cfg_index,
  input logic [31:0]                   cfg_data
);
  import fpr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != ST_RUN)))
    else $error("last flag disagrees with status");

  a_divz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_DIVZ) |-> (m_tdata[222:128] == '0))
    else $error("zero-divisor result carries an estimate");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ZERO) |->
      (m_tdata[159:128] == '0) && (m_tdata[222:192] == 31'h7fff_ffff))
    else $error("exact-zero result has wrong estimate or error");

endmodule

bind false_position_poly_root fpr_checker u_fpr_checker (.*);
